@@ rtl/h2r_pkg.sv @@
// h2r_pkg: shared types and constants for the hsv to rgb converter
// word structs for both channels, hue sector codes, reciprocal constants
// no dependencies
`timescale 1ns / 1ps

package h2r_pkg;

   typedef struct packed {
      logic signed [15:0] hue;
      logic [7:0]         sat;
      logic [7:0]         val;
   } req_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_word_type;

   typedef enum logic [2:0] {
      SEC_RED,
      SEC_YELLOW,
      SEC_GREEN,
      SEC_CYAN,
      SEC_BLUE,
      SEC_MAGENTA
   } sector_type;

   localparam int NUM_STAGES = 8;

   // hue offset, a multiple of 360 that makes every signed hue positive
   localparam logic [16:0] HUE_OFFSET = 17'd33120;
   localparam logic [16:0] HUE_PERIOD = 17'd360;
   localparam logic [9:0]  HUE_PERIOD_W = 10'd360;

   // floor(x / 360) or one less, for x below 2^17
   localparam logic [16:0] RECIP_360       = 17'd93206;
   localparam int          RECIP_360_SHIFT = 25;

   // exact floor(x / 60) for x up to 60 * 255
   localparam logic [14:0] RECIP_60        = 15'd17477;
   localparam int          RECIP_60_SHIFT  = 20;

   // exact floor(x / 255) for x up to 255 * 255
   localparam logic [17:0] RECIP_255       = 18'd131587;
   localparam int          RECIP_255_SHIFT = 25;

   localparam logic [8:0] SEC_BOUND_1 = 9'd60;
   localparam logic [8:0] SEC_BOUND_2 = 9'd120;
   localparam logic [8:0] SEC_BOUND_3 = 9'd180;
   localparam logic [8:0] SEC_BOUND_4 = 9'd240;
   localparam logic [8:0] SEC_BOUND_5 = 9'd300;

   localparam logic [5:0] SECTOR_SPAN = 6'd60;
   localparam logic [7:0] CHAN_MAX    = 8'd255;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// hsv_to_rgb_converter: integer hsv to 8-bit rgb conversion, eight stage pipeline
// depends on h2r_pkg for word types, sector codes and reciprocal constants
`timescale 1ns / 1ps

// Converts one HSV word (signed hue in degrees, 8-bit saturation and value) into
// one RGB word per input word. The hue is wrapped into 0..359, split into a
// sector and a fraction, and the p, q and t terms are formed with truncating
// divisions by 60 and 255, each done as a multiply by a reciprocal. The pipeline
// has eight register stages, and a new word can be taken every cycle unless a
// stall on rsp_ready holds it back. Each stage has its own valid bit and moves
// whenever the stage after it has room, so a stall on rsp_ready only holds back
// the stages that are full and fills any bubbles.

module hsv_to_rgb_converter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  h2r_pkg::req_word_type req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output h2r_pkg::rsp_word_type rsp
);

   localparam int Q360_LSB = h2r_pkg::RECIP_360_SHIFT;
   localparam int D60_LSB  = h2r_pkg::RECIP_60_SHIFT;
   localparam int D255_LSB = h2r_pkg::RECIP_255_SHIFT;

   logic [h2r_pkg::NUM_STAGES-1:0] vld_ff;
   logic [h2r_pkg::NUM_STAGES-1:0] stg_rdy;

   // stage 1: offset hue, reciprocal multiply by 1/360
   logic [16:0] x_in, x_ff;
   logic [33:0] q360_prod;
   logic [7:0]  q360_ff;
   logic [7:0]  sat1_ff, val1_ff;

   // stage 2: remainder and correction
   logic [16:0] rem_full;
   logic [9:0]  rem_raw;
   logic [8:0]  hu_in, hu_ff;
   logic [7:0]  sat2_ff, val2_ff;

   // stage 3: sector and fraction
   h2r_pkg::sector_type sec_in, sec3_ff;
   logic [8:0]  sec_base;
   logic [8:0]  frac_full;
   logic [5:0]  f_ff;
   logic [7:0]  sat3_ff, val3_ff;

   // stage 4: fraction and its complement times saturation, 255 minus saturation
   logic [13:0] fs_ff, gs_ff;
   logic [7:0]  pa_ff;
   h2r_pkg::sector_type sec4_ff;
   logic [7:0]  val4_ff;

   // stage 5: divide by 60
   logic [28:0] fs_prod, gs_prod;
   logic [7:0]  qa_ff, ta_ff, pa5_ff;
   h2r_pkg::sector_type sec5_ff;
   logic [7:0]  val5_ff;

   // stage 6: scale by value
   logic [15:0] pm_ff, qm_ff, tm_ff;
   h2r_pkg::sector_type sec6_ff;
   logic [7:0]  val6_ff;

   // stage 7: divide by 255
   logic [33:0] p_prod, q_prod, t_prod;
   logic [7:0]  p_ff, q_ff, t_ff;
   h2r_pkg::sector_type sec7_ff;
   logic [7:0]  val7_ff;

   // stage 8: channel routing
   h2r_pkg::rsp_word_type rsp_in, rsp_ff;

   always_comb begin
      stg_rdy[h2r_pkg::NUM_STAGES-1] = ~vld_ff[h2r_pkg::NUM_STAGES-1] | rsp_ready;
      for (int i = h2r_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         stg_rdy[i] = ~vld_ff[i] | stg_rdy[i+1];
      end
   end

   assign req_ready = stg_rdy[0];
   assign rsp_valid = vld_ff[h2r_pkg::NUM_STAGES-1];
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stg_rdy[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < h2r_pkg::NUM_STAGES; i++) begin
            if (stg_rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // stage 1
   assign x_in      = {req.hue[15], req.hue} + h2r_pkg::HUE_OFFSET;
   assign q360_prod = {17'b0, x_in} * {17'b0, h2r_pkg::RECIP_360};

   always_ff @(posedge clock) begin
      if (stg_rdy[0]) begin
         x_ff    <= x_in;
         q360_ff <= q360_prod[Q360_LSB+7:Q360_LSB];
         sat1_ff <= req.sat;
         val1_ff <= req.val;
      end
   end

   // stage 2
   assign rem_full = x_ff - ({9'b0, q360_ff} * h2r_pkg::HUE_PERIOD);
   assign rem_raw  = rem_full[9:0];

   always_comb begin
      if (rem_raw >= h2r_pkg::HUE_PERIOD_W) begin
         hu_in = 9'(rem_raw - h2r_pkg::HUE_PERIOD_W);
      end else begin
         hu_in = rem_raw[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[1]) begin
         hu_ff   <= hu_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
      end
   end

   // stage 3
   always_comb begin
      if (hu_ff >= h2r_pkg::SEC_BOUND_5) begin
         sec_in   = h2r_pkg::SEC_MAGENTA;
         sec_base = h2r_pkg::SEC_BOUND_5;
      end else if (hu_ff >= h2r_pkg::SEC_BOUND_4) begin
         sec_in   = h2r_pkg::SEC_BLUE;
         sec_base = h2r_pkg::SEC_BOUND_4;
      end else if (hu_ff >= h2r_pkg::SEC_BOUND_3) begin
         sec_in   = h2r_pkg::SEC_CYAN;
         sec_base = h2r_pkg::SEC_BOUND_3;
      end else if (hu_ff >= h2r_pkg::SEC_BOUND_2) begin
         sec_in   = h2r_pkg::SEC_GREEN;
         sec_base = h2r_pkg::SEC_BOUND_2;
      end else if (hu_ff >= h2r_pkg::SEC_BOUND_1) begin
         sec_in   = h2r_pkg::SEC_YELLOW;
         sec_base = h2r_pkg::SEC_BOUND_1;
      end else begin
         sec_in   = h2r_pkg::SEC_RED;
         sec_base = '0;
      end
      frac_full = hu_ff - sec_base;
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[2]) begin
         sec3_ff <= sec_in;
         f_ff    <= frac_full[5:0];
         sat3_ff <= sat2_ff;
         val3_ff <= val2_ff;
      end
   end

   // stage 4
   always_ff @(posedge clock) begin
      if (stg_rdy[3]) begin
         fs_ff   <= {8'b0, f_ff} * {6'b0, sat3_ff};
         gs_ff   <= {8'b0, h2r_pkg::SECTOR_SPAN - f_ff} * {6'b0, sat3_ff};
         pa_ff   <= h2r_pkg::CHAN_MAX - sat3_ff;
         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
      end
   end

   // stage 5
   assign fs_prod = {15'b0, fs_ff} * {14'b0, h2r_pkg::RECIP_60};
   assign gs_prod = {15'b0, gs_ff} * {14'b0, h2r_pkg::RECIP_60};

   always_ff @(posedge clock) begin
      if (stg_rdy[4]) begin
         qa_ff   <= h2r_pkg::CHAN_MAX - fs_prod[D60_LSB+7:D60_LSB];
         ta_ff   <= h2r_pkg::CHAN_MAX - gs_prod[D60_LSB+7:D60_LSB];
         pa5_ff  <= pa_ff;
         sec5_ff <= sec4_ff;
         val5_ff <= val4_ff;
      end
   end

   // stage 6
   always_ff @(posedge clock) begin
      if (stg_rdy[5]) begin
         pm_ff   <= {8'b0, val5_ff} * {8'b0, pa5_ff};
         qm_ff   <= {8'b0, val5_ff} * {8'b0, qa_ff};
         tm_ff   <= {8'b0, val5_ff} * {8'b0, ta_ff};
         sec6_ff <= sec5_ff;
         val6_ff <= val5_ff;
      end
   end

   // stage 7
   assign p_prod = {18'b0, pm_ff} * {16'b0, h2r_pkg::RECIP_255};
   assign q_prod = {18'b0, qm_ff} * {16'b0, h2r_pkg::RECIP_255};
   assign t_prod = {18'b0, tm_ff} * {16'b0, h2r_pkg::RECIP_255};

   always_ff @(posedge clock) begin
      if (stg_rdy[6]) begin
         p_ff    <= p_prod[D255_LSB+7:D255_LSB];
         q_ff    <= q_prod[D255_LSB+7:D255_LSB];
         t_ff    <= t_prod[D255_LSB+7:D255_LSB];
         sec7_ff <= sec6_ff;
         val7_ff <= val6_ff;
      end
   end

   // stage 8
   always_comb begin
      case (sec7_ff)
         h2r_pkg::SEC_RED: begin
            rsp_in = '{red: val7_ff, green: t_ff, blue: p_ff};
         end
         h2r_pkg::SEC_YELLOW: begin
            rsp_in = '{red: q_ff, green: val7_ff, blue: p_ff};
         end
         h2r_pkg::SEC_GREEN: begin
            rsp_in = '{red: p_ff, green: val7_ff, blue: t_ff};
         end
         h2r_pkg::SEC_CYAN: begin
            rsp_in = '{red: p_ff, green: q_ff, blue: val7_ff};
         end
         h2r_pkg::SEC_BLUE: begin
            rsp_in = '{red: t_ff, green: p_ff, blue: val7_ff};
         end
         default: begin
            rsp_in = '{red: val7_ff, green: p_ff, blue: q_ff};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stg_rdy[7]) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   hue_wrapped_a : assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (hu_ff < 9'd360))
      else $error("wrapped hue out of range");

   frac_range_a : assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (f_ff < h2r_pkg::SECTOR_SPAN))
      else $error("hue fraction out of range");

   p_smallest_a : assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] |-> ((p_ff <= q_ff) && (p_ff <= t_ff) && (p_ff <= val7_ff)))
      else $error("p term exceeds q, t or value");

   held_stage_a : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[3] && !stg_rdy[3]) |=> (vld_ff[3] && $stable(fs_ff) && $stable(gs_ff)))
      else $error("stalled stage lost its word");
`endif

endmodule

@@ tb/sv/h2r_checker.sv @@
// h2r_checker: watches both channels of the hsv to rgb converter, predicts each rgb word
// and compares it with the word that comes out; hands mismatch and pending counts upward
// depends on h2r_pkg for word types and sector codes
`timescale 1ns / 1ps

module h2r_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  h2r_pkg::req_word_type req,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  h2r_pkg::rsp_word_type rsp,
   output int                    mismatch_count,
   output int                    rgb_pending
);

   h2r_pkg::rsp_word_type rgb_due[$];
   int                    errs = 0;

   function automatic h2r_pkg::rsp_word_type convert_hsv(input h2r_pkg::req_word_type w);
      int                    h;
      int unsigned           hu, f, s, v, p, q, t;
      h2r_pkg::sector_type   sec;
      h2r_pkg::rsp_word_type c;
      h = $signed(w.hue);
      h = h % 360;
      if (h < 0) begin
         h = h + 360;
      end
      hu  = h;
      sec = h2r_pkg::sector_type'(hu / 60);
      f   = hu % 60;
      s   = w.sat;
      v   = w.val;
      p   = v * (255 - s) / 255;
      q   = v * (255 - f * s / 60) / 255;
      t   = v * (255 - (60 - f) * s / 60) / 255;
      case (sec)
         h2r_pkg::SEC_RED: begin
            c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
         end
         h2r_pkg::SEC_YELLOW: begin
            c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
         end
         h2r_pkg::SEC_GREEN: begin
            c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
         end
         h2r_pkg::SEC_CYAN: begin
            c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
         end
         h2r_pkg::SEC_BLUE: begin
            c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
         end
         default: begin
            c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
         end
      endcase
      return c;
   endfunction

   always @(posedge clock) begin
      h2r_pkg::rsp_word_type want;
      if (!reset) begin
         // result side first, so a word taken at this edge cannot match itself
         if (rsp_valid && rsp_ready) begin
            if (rgb_due.size() == 0) begin
               $error("unexpected rgb word: red %0d green %0d blue %0d",
                      rsp.red, rsp.green, rsp.blue);
               errs++;
            end else begin
               want = rgb_due.pop_front();
               if (rsp.red !== want.red) begin
                  $error("red expected %0d actual %0d", want.red, rsp.red);
                  errs++;
               end
               if (rsp.green !== want.green) begin
                  $error("green expected %0d actual %0d", want.green, rsp.green);
                  errs++;
               end
               if (rsp.blue !== want.blue) begin
                  $error("blue expected %0d actual %0d", want.blue, rsp.blue);
                  errs++;
               end
            end
         end
         if (req_valid && req_ready) begin
            rgb_due.push_back(convert_hsv(req));
         end
      end
      mismatch_count <= errs;
      rgb_pending    <= rgb_due.size();
   end

endmodule

@@ tb/sv/tb_hsv_to_rgb_converter.sv @@
// tb_hsv_to_rgb_converter: drives hsv words into the converter with random gaps and stalls,
// corner words first and then random ones; prints the verdict from the checker's counts
// depends on h2r_pkg, hsv_to_rgb_converter and h2r_checker
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   h2r_pkg::req_word_type req       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   h2r_pkg::rsp_word_type rsp;
   logic                  steady    = 1'b0;
   int                    mismatch_count;
   int                    rgb_pending;

   hsv_to_rgb_converter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   h2r_checker check_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req            (req),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp            (rsp),
      .mismatch_count (mismatch_count),
      .rgb_pending    (rgb_pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic h2r_pkg::req_word_type make_hsv(input int h, input int s, input int v);
      h2r_pkg::req_word_type w;
      w.hue = 16'(h);
      w.sat = 8'(s);
      w.val = 8'(v);
      return w;
   endfunction

   function automatic int draw_gap();
      return steady ? 0 : int'($urandom_range(0, 11));
   endfunction

   task automatic send_word(input h2r_pkg::req_word_type w);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_rgb();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rgb_pending != 0) @(posedge clock);
   endtask

   // result side: random stalls per word
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      h2r_pkg::req_word_type w;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // corners: hue extremes, wrap points, sector edges, grey, black, full
      send_word(make_hsv(-32768, 255, 255));
      send_word(make_hsv(32767, 255, 255));
      send_word(make_hsv(-1, 200, 180));
      send_word(make_hsv(0, 255, 255));
      send_word(make_hsv(359, 255, 255));
      send_word(make_hsv(360, 255, 255));
      send_word(make_hsv(720, 128, 200));
      send_word(make_hsv(-360, 128, 200));
      send_word(make_hsv(59, 255, 255));
      send_word(make_hsv(60, 255, 255));
      send_word(make_hsv(120, 255, 255));
      send_word(make_hsv(180, 255, 255));
      send_word(make_hsv(240, 255, 255));
      send_word(make_hsv(300, 255, 255));
      send_word(make_hsv(30, 255, 255));
      send_word(make_hsv(90, 100, 150));
      send_word(make_hsv(150, 77, 33));
      send_word(make_hsv(210, 1, 254));
      send_word(make_hsv(270, 254, 1));
      send_word(make_hsv(330, 170, 99));
      send_word(make_hsv(45, 0, 200));
      send_word(make_hsv(200, 255, 0));
      send_word(make_hsv(-32767, 0, 0));
      send_word(make_hsv(32400, 255, 128));
      drain_rgb();

      for (int n = 0; n < 1100; n++) begin
         if (n % 64 == 0) begin
            steady <= ($urandom_range(0, 3) == 0);
         end
         if (n == 550) begin
            drain_rgb();
         end
         if ($urandom_range(0, 2) == 0) begin
            w.hue = 16'($urandom);
         end else begin
            w.hue = 16'($urandom_range(0, 2160) - 720);
         end
         case ($urandom_range(0, 7))
            0:       w.sat = 8'd0;
            1:       w.sat = 8'd255;
            default: w.sat = 8'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0:       w.val = 8'd0;
            1:       w.val = 8'd255;
            default: w.val = 8'($urandom);
         endcase
         send_word(w);
      end

      drain_rgb();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && rgb_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
